// ===== sv/slcrc_pkg.sv =====
`default_nettype none

package slcrc_pkg;

  // Default number of bytes one frame may hold, sync bytes included.
  localparam int unsigned FrameCapacityDefault = 256;

  localparam logic [7:0]  SyncFirst  = 8'hAA;
  localparam logic [7:0]  SyncSecond = 8'h55;
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;

  // Reset values of the configuration registers.
  localparam logic [7:0]  MinLengthReset = 8'd8;
  localparam logic [7:0]  MaxLengthReset = 8'd252;
  localparam logic [15:0] TimeoutReset   = 16'd100;

  typedef enum logic [1:0] {
    CFG_MIN_LENGTH = 2'd0,
    CFG_MAX_LENGTH = 2'd1,
    CFG_TIMEOUT    = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_FRAME = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OK      = 3'd1,
    EV_CRC     = 3'd2,
    EV_LEN     = 3'd3,
    EV_OVF     = 3'd4,
    EV_TIMEOUT = 3'd5
  } event_e;

  typedef struct packed {
    logic [7:0]  min_length;
    logic [7:0]  max_length;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // One classified input word as it travels from the front to the back.
  typedef struct packed {
    logic       is_tick;
    logic       is_sync1;
    logic       is_sync2;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_out;
    logic [7:0] byte_index;
    logic       frame_end;
    event_e     event_res;
  } res_t;

  // Feed one byte into a reflected CRC-32, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/slcrc_fifo.sv =====
`default_nettype none

module slcrc_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [Width-1:0]      data_o
);

  // Two entries, so a stall on one side does not at once halt the other.
  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/slcrc_front.sv =====
`default_nettype none

module slcrc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic          op_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          item_pop_i,
  output logic               item_empty_o,
  output slcrc_pkg::item_t   item_o
);
  import slcrc_pkg::*;

  item_t item_in;

  // Classify the word: tick or byte, and which sync byte it matches.
  always_comb begin
    item_in.is_tick  = op_i;
    item_in.is_sync1 = (rx_byte_i == SyncFirst);
    item_in.is_sync2 = (rx_byte_i == SyncSecond);
    item_in.data     = rx_byte_i;
  end

  // Queue that decouples the input from the frame engine.
  slcrc_fifo #(
    .Width($bits(item_t))
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .data_i (item_in),
    .pop_i  (item_pop_i),
    .empty_o(item_empty_o),
    .data_o (item_o)
  );

endmodule

`default_nettype wire

// ===== sv/slcrc_back.sv =====
`default_nettype none

module slcrc_back #(
  parameter int unsigned FrameCapacity = slcrc_pkg::FrameCapacityDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire slcrc_pkg::cfg_t  cfg_i,
  input  wire logic          item_empty_i,
  input  wire slcrc_pkg::item_t item_i,
  output logic               item_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output slcrc_pkg::res_t    res_o
);
  import slcrc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [8:0]  count_q, count_d;
  logic [8:0]  exp_q, exp_d;
  logic [15:0] ticks_q, ticks_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] win_q, win_d;

  logic        res_full;
  res_t        res;

  logic [8:0]  cnt_inc;
  logic [31:0] win_push, crc_push;
  logic [15:0] len;
  logic        at_len, len_bad, done, crc_ok, overflow, timeout;
  logic [8:0]  exp_new;
  logic [15:0] ticks_sat;

  // An item is taken whenever a result slot is free.
  assign item_pop_o = !item_empty_i && !res_full;

  // Shifting a byte into the window; the byte that leaves feeds the CRC.
  assign cnt_inc  = count_q + 9'd1;
  assign win_push = {item_i.data, win_q[31:8]};
  assign crc_push = (count_q >= 9'd4) ? crc_byte(crc_q, win_q[7:0]) : crc_q;

  // Length check once the fourth byte is in.
  assign len      = win_push[31:16];
  assign at_len   = (cnt_inc == 9'd4);
  assign len_bad  = at_len && ((len < {8'h00, cfg_i.min_length}) ||
                               (len > {8'h00, cfg_i.max_length}));
  assign exp_new  = at_len ? ({1'b0, len[7:0]} + 9'd4) : exp_q;
  assign done     = !len_bad && (exp_new != 9'd0) && (cnt_inc >= exp_new);
  assign crc_ok   = (~crc_push == win_push);
  assign overflow = (count_q >= 9'(FrameCapacity));

  // Tick counting saturates at the top of its range.
  assign ticks_sat = (&ticks_q) ? ticks_q : ticks_q + 16'd1;
  assign timeout   = (ticks_sat > cfg_i.timeout_ticks);

  // Next state of the frame engine.
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    exp_d   = exp_q;
    ticks_d = ticks_q;
    crc_d   = crc_q;
    win_d   = win_q;
    if (item_pop_o) begin
      if (item_i.is_tick) begin
        if (phase_q != PH_HUNT1) begin
          if (timeout) begin
            phase_d = PH_HUNT1;
            count_d = 9'd0;
            exp_d   = 9'd0;
            ticks_d = 16'd0;
            crc_d   = CrcInit;
            win_d   = 32'h0;
          end else begin
            ticks_d = ticks_sat;
          end
        end
      end else begin
        unique case (phase_q)
          PH_HUNT1: begin
            if (item_i.is_sync1) begin
              phase_d = PH_HUNT2;
              count_d = 9'd1;
              exp_d   = 9'd0;
              ticks_d = 16'd0;
              crc_d   = CrcInit;
              win_d   = {SyncFirst, 24'h0};
            end
          end
          PH_HUNT2: begin
            if (item_i.is_sync2) begin
              phase_d = PH_FRAME;
              count_d = cnt_inc;
              crc_d   = crc_push;
              win_d   = win_push;
            end else if (item_i.is_sync1) begin
              phase_d = PH_HUNT2;
              count_d = 9'd1;
              exp_d   = 9'd0;
              ticks_d = 16'd0;
              crc_d   = CrcInit;
              win_d   = {SyncFirst, 24'h0};
            end else begin
              phase_d = PH_HUNT1;
              count_d = 9'd0;
              exp_d   = 9'd0;
              ticks_d = 16'd0;
              crc_d   = CrcInit;
              win_d   = 32'h0;
            end
          end
          PH_FRAME: begin
            if (overflow || len_bad || done) begin
              phase_d = PH_HUNT1;
              count_d = 9'd0;
              exp_d   = 9'd0;
              ticks_d = 16'd0;
              crc_d   = CrcInit;
              win_d   = 32'h0;
            end else begin
              count_d = cnt_inc;
              exp_d   = exp_new;
              crc_d   = crc_push;
              win_d   = win_push;
            end
          end
          default: begin
            phase_d = PH_HUNT1;
          end
        endcase
      end
    end
  end

  // Result word for the item being taken.
  always_comb begin
    res = '{byte_valid: 1'b0, byte_out: 8'h00, byte_index: 8'h00,
            frame_end: 1'b0, event_res: EV_NONE};
    if (item_i.is_tick) begin
      if ((phase_q != PH_HUNT1) && timeout) begin
        res.frame_end = 1'b1;
        res.event_res = EV_TIMEOUT;
      end
    end else begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (item_i.is_sync1) begin
            res.byte_valid = 1'b1;
            res.byte_out   = item_i.data;
          end
        end
        PH_HUNT2: begin
          if (item_i.is_sync2) begin
            res.byte_valid = 1'b1;
            res.byte_out   = item_i.data;
            res.byte_index = 8'd1;
          end else if (item_i.is_sync1) begin
            res.byte_valid = 1'b1;
            res.byte_out   = item_i.data;
          end
        end
        PH_FRAME: begin
          if (overflow) begin
            res.frame_end = 1'b1;
            res.event_res = EV_OVF;
          end else begin
            res.byte_valid = 1'b1;
            res.byte_out   = item_i.data;
            res.byte_index = count_q[7:0];
            if (len_bad) begin
              res.frame_end = 1'b1;
              res.event_res = EV_LEN;
            end else if (done) begin
              res.frame_end = 1'b1;
              res.event_res = crc_ok ? EV_OK : EV_CRC;
            end
          end
        end
        default: begin
          res.byte_valid = 1'b0;
        end
      endcase
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      count_q <= 9'd0;
      exp_q   <= 9'd0;
      ticks_q <= 16'd0;
      crc_q   <= CrcInit;
      win_q   <= 32'h0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      exp_q   <= exp_d;
      ticks_q <= ticks_d;
      crc_q   <= crc_d;
      win_q   <= win_d;
    end
  end

  // Result queue toward the receiver.
  slcrc_fifo #(
    .Width($bits(res_t))
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (item_pop_o),
    .full_o (res_full),
    .data_i (res),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_o)
  );

`ifndef SYNTHESIS
  a_end_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (res.frame_end == (res.event_res != EV_NONE)))
    else $error("frame end and event code disagree");

  a_hunt1_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT1) |-> (count_q == 9'd0 && ticks_q == 16'd0))
    else $error("hunt state holds stale frame data");

  a_hunt2_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT2) |-> (count_q == 9'd1))
    else $error("byte count wrong while waiting for second sync byte");

  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FRAME) |-> (count_q >= 9'd2 && count_q <= 9'(FrameCapacity)))
    else $error("byte count out of range inside a frame");

  a_end_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_pop_o && res.frame_end) |=> (phase_q == PH_HUNT1))
    else $error("frame end did not return to the hunt");
`endif

endmodule

`default_nettype wire

// ===== sv/sync_length_crc32_frame_receiver_unit.sv =====
// Frame receiver for a byte-serial link with sync pair, length field and CRC-32.
// Input channel: push a word with op_i = 0 for a received byte on rx_byte_i, or
// op_i = 1 for a one millisecond tick. A word is taken when push is high and
// full is low. Every word yields exactly one result word, in order.
// Result channel: while empty is low the oldest result sits on byte_valid_o,
// byte_out_o, byte_index_o, frame_end_o and event_res_o; pop takes it.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 min length, 1 max length, 2 timeout ticks) at once; write only when idle.
// A word passes through the input queue and then the frame engine, which
// writes the result queue. Throughput is one word per cycle while results
// are popped, as the frame engine handles each word with its byte-wide CRC.
// When the receiver stalls, the two-entry result queue fills, the engine holds,
// the input queue fills and full rises; no word is lost.
// Reset empties both queues, restores the register defaults (8, 252, 100) and
// returns the engine to hunting the first sync byte.
`default_nettype none

module sync_length_crc32_frame_receiver_unit #(
  parameter int unsigned FRAME_CAPACITY = slcrc_pkg::FrameCapacityDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic        op_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             byte_valid_o,
  output logic [7:0]       byte_out_o,
  output logic [7:0]       byte_index_o,
  output logic             frame_end_o,
  output logic [2:0]       event_res_o
);
  import slcrc_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  logic  item_empty, item_pop;
  res_t  res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_length    <= MinLengthReset;
      cfg_q.max_length    <= MaxLengthReset;
      cfg_q.timeout_ticks <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_LENGTH: cfg_q.min_length    <= cfg_wdata_i[7:0];
        CFG_MAX_LENGTH: cfg_q.max_length    <= cfg_wdata_i[7:0];
        CFG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_wdata_i;
        default:        cfg_q               <= cfg_q;
      endcase
    end
  end

  slcrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .rx_byte_i   (rx_byte_i),
    .item_pop_i  (item_pop),
    .item_empty_o(item_empty),
    .item_o      (item)
  );

  slcrc_back #(
    .FrameCapacity(FRAME_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_empty_i(item_empty),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  // Result fields onto their ports.
  assign byte_valid_o = res.byte_valid;
  assign byte_out_o   = res.byte_out;
  assign byte_index_o = res.byte_index;
  assign frame_end_o  = res.frame_end;
  assign event_res_o  = res.event_res;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slcrc_pkg::*;

  // Input word kinds.
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef logic [7:0] byte_q_t[$];

  // Predicts the receiver's result word for every accepted input word and
  // checks the words that come out against those predictions, in order.
  class frame_rx_scoreboard;
    logic [7:0]  min_len;
    logic [7:0]  max_len;
    logic [15:0] tmo;
    phase_e      ph;
    logic [8:0]  count;
    logic [8:0]  total;
    logic [15:0] ticks;
    logic [31:0] crc;
    logic [31:0] window;
    res_t        words_due[$];
    int unsigned mismatches;

    function new();
      min_len = MinLengthReset;
      max_len = MaxLengthReset;
      tmo = TimeoutReset;
      mismatches = 0;
      clear();
    endfunction

    // Reflected CRC-32, one byte at a time.
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
        if (x[0]) begin
          x = (x >> 1) ^ CrcPoly;
        end else begin
          x = x >> 1;
        end
      end
      return x;
    endfunction

    function void clear();
      ph = PH_HUNT1;
      count = '0;
      total = '0;
      ticks = '0;
      crc = CrcInit;
      window = '0;
    endfunction

    // A first sync byte opens a new frame.
    function void open_frame();
      clear();
      ph = PH_HUNT2;
      count = 9'd1;
      window = {SyncFirst, 24'h0};
    endfunction

    // The oldest byte of the four-byte window goes into the CRC once the
    // window is full; the trailing four bytes therefore never reach it.
    function void shift_in(logic [7:0] b);
      if (count >= 9'd4) crc = crc_step(crc, window[7:0]);
      window = {b, window[31:8]};
      count = count + 9'd1;
    endfunction

    function void set_reg(cfg_index_e idx, logic [15:0] v);
      case (idx)
        CFG_MIN_LENGTH: min_len = v[7:0];
        CFG_MAX_LENGTH: max_len = v[7:0];
        CFG_TIMEOUT: tmo = v;
        default: ;
      endcase
    endfunction

    function void predict_word(logic is_tick, logic [7:0] b);
      res_t r;
      logic [15:0] len;
      r.byte_valid = 1'b0;
      r.byte_out = 8'h00;
      r.byte_index = 8'h00;
      r.frame_end = 1'b0;
      r.event_res = EV_NONE;
      if (is_tick == OpTick) begin
        // Ticks only count while a frame is under way.
        if (ph != PH_HUNT1) begin
          if (ticks != 16'hFFFF) ticks++;
          if (ticks > tmo) begin
            r.frame_end = 1'b1;
            r.event_res = EV_TIMEOUT;
            clear();
          end
        end
      end else if (ph == PH_HUNT1) begin
        if (b == SyncFirst) begin
          open_frame();
          r.byte_valid = 1'b1;
          r.byte_out = b;
        end
      end else if (ph == PH_HUNT2) begin
        if (b == SyncSecond) begin
          shift_in(b);
          ph = PH_FRAME;
          r.byte_valid = 1'b1;
          r.byte_out = b;
          r.byte_index = 8'd1;
        end else if (b == SyncFirst) begin
          open_frame();
          r.byte_valid = 1'b1;
          r.byte_out = b;
        end else begin
          clear();
        end
      end else if (count >= FrameCapacityDefault) begin
        r.frame_end = 1'b1;
        r.event_res = EV_OVF;
        clear();
      end else begin
        r.byte_valid = 1'b1;
        r.byte_out = b;
        r.byte_index = count[7:0];
        shift_in(b);
        // The length field is complete with the fourth byte.
        if (count == 9'd4) begin
          len = window[31:16];
          if (len < min_len || len > max_len) begin
            r.frame_end = 1'b1;
            r.event_res = EV_LEN;
            clear();
          end else begin
            total = 9'(len + 16'd4);
          end
        end
        if (ph == PH_FRAME && total != 0 && count >= total) begin
          r.frame_end = 1'b1;
          r.event_res = (~crc == window) ? EV_OK : EV_CRC;
          clear();
        end
      end
      words_due.push_back(r);
    endfunction

    function void check_result(logic v, logic [7:0] bo, logic [7:0] bi, logic fe,
                               logic [2:0] ev);
      res_t want;
      if (words_due.size() == 0) begin
        $error("result word arrived with nothing expected");
        mismatches++;
        return;
      end
      want = words_due.pop_front();
      if (v !== want.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", want.byte_valid, v);
        mismatches++;
      end
      if (bo !== want.byte_out) begin
        $error("byte_out: expected %0h, got %0h", want.byte_out, bo);
        mismatches++;
      end
      if (bi !== want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, bi);
        mismatches++;
      end
      if (fe !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, fe);
        mismatches++;
      end
      if (ev !== want.event_res) begin
        $error("event_res: expected %0d, got %0d", want.event_res, ev);
        mismatches++;
      end
    endfunction

    function void report_leftover();
      if (words_due.size() != 0) begin
        $error("%0d result words never arrived", words_due.size());
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_MIN_LENGTH;
  logic [15:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        op_i = OpByte;
  logic [7:0]  rx_byte_i = '0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic        byte_valid_o;
  logic [7:0]  byte_out_o;
  logic [7:0]  byte_index_o;
  logic        frame_end_o;
  logic [2:0]  event_res_o;

  frame_rx_scoreboard sb = new();
  int unsigned words_sent = 0;
  int unsigned pop_hold = 0;
  bit          no_gaps = 1'b0;

  sync_length_crc32_frame_receiver_unit dut (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push(push),
    .full(full),
    .op_i(op_i),
    .rx_byte_i(rx_byte_i),
    .empty(empty),
    .pop(pop),
    .byte_valid_o(byte_valid_o),
    .byte_out_o(byte_out_o),
    .byte_index_o(byte_index_o),
    .frame_end_o(frame_end_o),
    .event_res_o(event_res_o)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Lengths cluster just above the minimum, with boundary values, overflow
  // candidates and arbitrary 16-bit values mixed in.
  function automatic logic [15:0] pick_length(logic [7:0] mn, logic [7:0] mx);
    int unsigned r;
    int unsigned hi;
    r = $urandom_range(0, 99);
    hi = (mx > mn + 12) ? mn + 12 : mx;
    if (hi < mn) hi = mn;
    if (r < 65) return 16'($urandom_range(mn, hi));
    if (r < 77) begin
      case ($urandom_range(0, 3))
        0: return 16'(mn) - 16'd1;
        1: return 16'(mn);
        2: return 16'(mx);
        default: return 16'(mx) + 16'd1;
      endcase
    end
    if (r < 87) return 16'($urandom_range(0, 255));
    if (r < 92) return 16'($urandom_range(253, 255));
    return 16'($urandom());
  endfunction

  // Sync pair, length, payload and a correct CRC, least significant byte first.
  function automatic byte_q_t build_frame(logic [15:0] len);
    byte_q_t q;
    logic [31:0] c;
    int unsigned body;
    q = '{SyncFirst, SyncSecond, len[7:0], len[15:8]};
    body = (len >= 16'd4 && len <= 16'd255) ? len - 4 : 0;
    repeat (body) q.push_back(8'($urandom()));
    c = CrcInit;
    foreach (q[i]) c = frame_rx_scoreboard::crc_step(c, q[i]);
    c = ~c;
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    q.push_back(c[23:16]);
    q.push_back(c[31:24]);
    return q;
  endfunction

  // Offers one word from a falling edge and holds it until it is taken.
  task automatic send_word(logic is_tick, logic [7:0] b);
    int unsigned gap;
    op_i = is_tick;
    rx_byte_i = b;
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.predict_word(is_tick, b);
    words_sent++;
    @(negedge clk);
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drive_frame(byte_q_t f, int unsigned tick_odds);
    foreach (f[i]) begin
      if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) begin
        send_word(OpTick, 8'($urandom()));
      end
      send_word(OpByte, f[i]);
    end
  endtask

  // Line noise between frames: ticks, stray first sync bytes and random bytes.
  task automatic send_noise(int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: send_word(OpTick, 8'($urandom()));
        1: send_word(OpByte, SyncFirst);
        default: send_word(OpByte, 8'($urandom()));
      endcase
    end
  endtask

  // Registers change only once every result word has been taken.
  task automatic wait_idle();
    push = 1'b0;
    while (sb.words_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [15:0] v);
    cfg_index_i = idx;
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Upper data bits of the 8-bit registers are random and must be ignored.
  task automatic apply_config(logic [7:0] mn, logic [7:0] mx, logic [15:0] tmo);
    wait_idle();
    write_reg(CFG_MIN_LENGTH, {8'($urandom()), mn});
    write_reg(CFG_MAX_LENGTH, {8'($urandom()), mx});
    write_reg(CFG_TIMEOUT, tmo);
  endtask

  // Mostly well-formed frames with random content; some carry a flipped bit,
  // some are cut short, and noise falls between them.
  task automatic run_phase(logic [7:0] mn, logic [7:0] mx, logic [15:0] tmo,
                           int unsigned budget);
    byte_q_t f;
    int unsigned first;
    int unsigned r;
    int unsigned k;
    apply_config(mn, mx, tmo);
    first = words_sent;
    while (words_sent - first < budget) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      f = build_frame(pick_length(mn, mx));
      r = $urandom_range(0, 99);
      if (r < 12) begin
        k = $urandom_range(0, f.size() - 1);
        f[k] = f[k] ^ (8'h01 << $urandom_range(0, 7));
      end else if (r < 22) begin
        k = $urandom_range(1, f.size() - 1);
        while (f.size() > k) f.delete(f.size() - 1);
      end
      drive_frame(f, 16);
      if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6));
    end
  endtask

  // Result side: pop with random stalls.
  always @(negedge clk) begin
    if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if (!no_gaps && $urandom_range(0, 3) == 0) pop_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_ni && pop && !empty) begin
      sb.check_result(byte_valid_o, byte_out_o, byte_index_o, frame_end_o, event_res_o);
    end
  end

  initial begin
    byte_q_t f;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk);

    // Reset settings: tick while hunting, broken sync, repeated first sync
    // byte, length below and above the limits, then a good minimal frame.
    send_word(OpTick, 8'hFF);
    send_word(OpByte, 8'h00);
    send_word(OpByte, SyncFirst);
    send_word(OpByte, 8'h13);
    send_word(OpByte, SyncFirst);
    send_word(OpByte, SyncFirst);
    send_word(OpByte, SyncSecond);
    send_word(OpByte, 8'h05);
    send_word(OpByte, 8'h00);
    drive_frame('{SyncFirst, SyncSecond, 8'h00, 8'h01}, 0);
    drive_frame(build_frame(16'd8), 0);

    // Zero timeout aborts on the first tick; a zero length ends at byte four.
    apply_config(8'd0, 8'd255, 16'd0);
    send_word(OpByte, SyncFirst);
    send_word(OpTick, 8'h00);
    drive_frame(build_frame(16'd0), 0);

    // Maximum timeout: a run of ticks inside a frame never expires.
    apply_config(8'd4, 8'd252, 16'hFFFF);
    no_gaps = 1'b1;
    f = build_frame(16'd6);
    send_word(OpByte, f[0]);
    send_word(OpByte, f[1]);
    repeat (40) send_word(OpTick, 8'($urandom()));
    for (int i = 2; i < f.size(); i++) send_word(OpByte, f[i]);

    run_phase(8'd4, 8'd24, 16'd300, 250);
    run_phase(8'd0, 8'd255, 16'd2000, 300);
    run_phase(8'd8, 8'd252, 16'd3, 200);
    run_phase(8'd252, 8'd252, 16'hFFFF, 200);
    run_phase(8'd4, 8'd252, 16'd0, 150);
    run_phase(8'd40, 8'd10, 16'd50, 150);
    run_phase(8'd4, 8'd252, 16'd100, 250);

    // Drain what is still in flight.
    push = 1'b0;
    for (int i = 0; i < 200000 && sb.words_due.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.report_leftover();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/slcrc_pkg.sv
sv/slcrc_fifo.sv
sv/slcrc_front.sv
sv/slcrc_back.sv
sv/sync_length_crc32_frame_receiver_unit.sv
dv/testbench.sv
